// ----- hw/rtl/trie_insert_lookup_macros.svh -----
// Assertion macros for the trie insert/lookup block.
// Used by the port-level checker; relies on clk and rst_n in the enclosing scope.
`ifndef TRIE_INSERT_LOOKUP_MACROS_SVH
`define TRIE_INSERT_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TIL_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/til_pkg.sv -----
// Shared types and constants for the trie insert/lookup block.
// No dependencies; imported by the controller, datapath and top level.
package til_pkg;

    localparam int MAX_NODES_DEF     = 1024;
    localparam int ALPHABET_SIZE_DEF = 52;
    localparam int SYMBOL_W          = 6;
    localparam int NODES_USED_W      = 11;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_MARK,
        ST_DONE
    } til_state_t;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic eval;
        logic mark_read;
        logic finish;
    } til_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic item_last;
        logic item_insert;
        logic out_free;
    } til_sts_t;

endpackage

// ----- hw/rtl/trie_insert_lookup.sv -----
// Top level of the trie insert/lookup block: controller plus datapath.
// Depends on til_pkg, til_ctrl and til_datapath.
//
//  channel | signals                                             | handshake
//  --------+-----------------------------------------------------+------------------
//  in      | mode, symbol_index, last_symbol                     | in_valid/in_stall
//  out     | prefix_found, is_stored_word, table_overflow,       | out_valid/out_stall
//          | nodes_used                                          |
//
// Sequence: a request that is not the last symbol of a word is accepted with the
// child-table read, then takes the walk step. A last symbol then goes to the result
// on insert, and on lookup first to the word-end mark read and then to the result.
// Reset: the child table and marks are swept clear, one entry a cycle, over all
// MAX_NODES * ALPHABET_SIZE entries (53248 by default); in_stall is high meanwhile.
// Stalls: the result sits in an output register, so the next request is taken
// while it waits; a new result holds in the controller until that register frees.
module trie_insert_lookup #(
    parameter int MAX_NODES     = til_pkg::MAX_NODES_DEF,
    parameter int ALPHABET_SIZE = til_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic [til_pkg::SYMBOL_W-1:0]     symbol_index,
    input  logic                             last_symbol,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             prefix_found,
    output logic                             is_stored_word,
    output logic                             table_overflow,
    output logic [til_pkg::NODES_USED_W-1:0] nodes_used
);
    import til_pkg::*;

    // Command and status bundles between controller and datapath.
    til_cmd_t cmd;
    til_sts_t sts;

    // Controller: sequences clear sweep, accept, walk step, mark read, result.
    til_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: node tables, walk state and the output register.
    til_datapath #(
        .MAX_NODES     (MAX_NODES),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .mode           (mode),
        .symbol_index   (symbol_index),
        .last_symbol    (last_symbol),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .prefix_found   (prefix_found),
        .is_stored_word (is_stored_word),
        .table_overflow (table_overflow),
        .nodes_used     (nodes_used)
    );

endmodule

// ----- hw/rtl/til_ctrl.sv -----
// Controller state machine for the trie insert/lookup block.
// Depends on til_pkg; drives datapath commands from datapath status.
module til_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  til_pkg::til_sts_t  sts,
    output til_pkg::til_cmd_t  cmd
);
    import til_pkg::*;

    til_state_t state_reg;
    til_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                priority if (!sts.item_last)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.item_insert)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            ST_MARK:
            begin
                cmd.mark_read = 1'b1;
            end
            ST_DONE:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/til_datapath.sv -----
// Datapath for the trie insert/lookup block: child table, word-end marks,
// walk registers and result register. Depends on til_pkg.
module til_datapath #(
    parameter int MAX_NODES     = til_pkg::MAX_NODES_DEF,
    parameter int ALPHABET_SIZE = til_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  til_pkg::til_cmd_t                cmd,
    output til_pkg::til_sts_t                sts,
    input  logic                             mode,
    input  logic [til_pkg::SYMBOL_W-1:0]     symbol_index,
    input  logic                             last_symbol,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             prefix_found,
    output logic                             is_stored_word,
    output logic                             table_overflow,
    output logic [til_pkg::NODES_USED_W-1:0] nodes_used
);
    import til_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int DEPTH  = MAX_NODES * ALPHABET_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [ADDR_W-1:0]   ALPHA_MUL  = ADDR_W'(ALPHABET_SIZE);
    localparam logic [ADDR_W-1:0]   SWEEP_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0]   SWEEP_MARK = ADDR_W'(MAX_NODES);
    localparam logic [SYMBOL_W:0]   ALPHA_LIM  = (SYMBOL_W + 1)'(ALPHABET_SIZE);
    localparam logic [CNT_W-1:0]    NODE_LIM   = CNT_W'(MAX_NODES);

    logic [NODE_W-1:0] child_mem [DEPTH];
    logic              mark_mem  [MAX_NODES];

    logic [NODE_W-1:0] current_reg;
    logic [NODE_W-1:0] current_next;
    logic [CNT_W-1:0]  free_reg;
    logic [CNT_W-1:0]  free_next;
    logic              failed_reg;
    logic              failed_next;
    logic              overflow_reg;
    logic              overflow_next;
    logic              read_ok_reg;
    logic [ADDR_W-1:0] sweep_reg;
    logic              out_valid_reg;

    logic              mode_reg;
    logic              last_reg;
    logic [ADDR_W-1:0] slot_reg;
    logic [NODE_W-1:0] rd_child_reg;
    logic              rd_mark_reg;
    logic              found_reg;
    logic              stored_reg;
    logic              ovf_out_reg;
    logic [NODES_USED_W-1:0] used_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic              read_ok;
    logic              child_we;
    logic [ADDR_W-1:0] child_waddr;
    logic [NODE_W-1:0] child_wdata;
    logic              mark_we;
    logic [NODE_W-1:0] mark_waddr;
    logic              mark_wdata;
    logic              stored_now;
    logic              out_free;

    assign rd_addr  = ADDR_W'(current_reg) * ALPHA_MUL + ADDR_W'(symbol_index);
    assign read_ok  = !failed_reg && ({1'b0, symbol_index} < ALPHA_LIM);
    assign out_free = !out_valid_reg || !out_stall;

    // Walk update: clear-sweep writes; follow, allocate, or drop the rest of the word; reset the walk on finish.
    always_comb
    begin
        current_next  = current_reg;
        free_next     = free_reg;
        failed_next   = failed_reg;
        overflow_next = overflow_reg;
        child_we      = 1'b0;
        child_waddr   = slot_reg;
        child_wdata   = free_reg[NODE_W-1:0];
        priority if (cmd.clear_step)
        begin
            child_we    = 1'b1;
            child_waddr = sweep_reg;
            child_wdata = '0;
        end
        else if (cmd.eval)
        begin
            priority if (!read_ok_reg)
            begin
                failed_next = 1'b1;
            end
            else if (rd_child_reg != '0)
            begin
                current_next = rd_child_reg;
            end
            else if (mode_reg == MODE_LOOKUP)
            begin
                failed_next = 1'b1;
            end
            else if (free_reg < NODE_LIM)
            begin
                child_we     = 1'b1;
                current_next = free_reg[NODE_W-1:0];
                free_next    = free_reg + CNT_W'(1);
            end
            else
            begin
                failed_next   = 1'b1;
                overflow_next = 1'b1;
            end
        end
        else if (cmd.finish)
        begin
            current_next  = '0;
            failed_next   = 1'b0;
            overflow_next = 1'b0;
        end
    end

    assign stored_now = !failed_reg && ((mode_reg == MODE_INSERT) || rd_mark_reg);

    always_comb
    begin
        mark_we    = 1'b0;
        mark_waddr = current_reg;
        mark_wdata = 1'b1;
        priority if (cmd.clear_step)
        begin
            mark_we    = sweep_reg < SWEEP_MARK;
            mark_waddr = sweep_reg[NODE_W-1:0];
            mark_wdata = 1'b0;
        end
        else if (cmd.finish)
        begin
            mark_we = (mode_reg == MODE_INSERT) && !failed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_reg   <= '0;
            free_reg      <= CNT_W'(1);
            failed_reg    <= 1'b0;
            overflow_reg  <= 1'b0;
            read_ok_reg   <= 1'b0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            current_reg  <= current_next;
            free_reg     <= free_next;
            failed_reg   <= failed_next;
            overflow_reg <= overflow_next;
            if (cmd.accept)
            begin
                read_ok_reg <= read_ok;
            end
            if (cmd.clear_step)
            begin
                sweep_reg <= sweep_reg + ADDR_W'(1);
            end
            priority if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request fields and result fields: no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg <= mode;
            last_reg <= last_symbol;
            slot_reg <= rd_addr;
        end
        if (cmd.finish)
        begin
            found_reg   <= !failed_reg;
            stored_reg  <= stored_now;
            ovf_out_reg <= overflow_reg;
            used_reg    <= NODES_USED_W'(free_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (child_we)
        begin
            child_mem[child_waddr] <= child_wdata;
        end
        if (cmd.accept)
        begin
            rd_child_reg <= child_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (cmd.mark_read)
        begin
            rd_mark_reg <= mark_mem[current_reg];
        end
    end

    assign sts.clear_done  = sweep_reg == SWEEP_LAST;
    assign sts.item_last   = last_reg;
    assign sts.item_insert = mode_reg == MODE_INSERT;
    assign sts.out_free    = out_free;

    assign out_valid      = out_valid_reg;
    assign prefix_found   = found_reg;
    assign is_stored_word = stored_reg;
    assign table_overflow = ovf_out_reg;
    assign nodes_used     = used_reg;

endmodule

// ----- hw/rtl/til_checker.sv -----
// Port-level checker for the trie insert/lookup block, bound to the top level.
// Depends on til_pkg and trie_insert_lookup_macros.svh.
`include "trie_insert_lookup_macros.svh"

module til_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic                             prefix_found,
    input logic                             is_stored_word,
    input logic                             table_overflow,
    input logic [til_pkg::NODES_USED_W-1:0] nodes_used
);
    import til_pkg::*;

    // Hold a stalled result.
    `TIL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(prefix_found) && $stable(is_stored_word) && $stable(table_overflow) && $stable(nodes_used), "stalled result changed")

    // A full walk never reports overflow.
    `TIL_ASSERT_IMPLY(a_found_no_ovf, out_valid, !(prefix_found && table_overflow), "found word also flagged overflow")

    // A stored word is always a found path.
    `TIL_ASSERT_IMPLY(a_stored_found, out_valid && is_stored_word, prefix_found, "stored word without path")

    // A new result is loaded only while requests are held off.
    `TIL_ASSERT_IMPLY(a_result_source, $rose(out_valid), $past(in_stall), "result appeared while idle")

endmodule

bind trie_insert_lookup til_checker u_til_checker (.*);
